// ===== rtl/core/es_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the exchange sorter.
// No dependencies.

package es_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STEP_W    = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD = 3'd0;
  localparam step_t STEP_RDA  = 3'd1;
  localparam step_t STEP_LDA  = 3'd2;
  localparam step_t STEP_CMP  = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;

  typedef enum logic [1:0] {
    RD_A     = 2'd0,
    RD_B     = 2'd1,
    RD_BNEXT = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_IN_LAST   = 3'd1,
    C_B_END     = 3'd2,
    C_BNEXT_END = 3'd3,
    C_A_LAST    = 3'd4
  } cond_e;

  typedef struct packed {
    logic    in_rdy;
    rd_sel_e rd_sel;
    logic    set_b;
    logic    ld_acc;
    logic    cmp;
    logic    emit;
    cond_e   cond;
    step_t   tgt;
    step_t   alt;
  } ctrl_t;

  typedef struct packed {
    logic in_last_acc;
    logic b_end;
    logic bnext_end;
    logic a_last;
    logic out_free;
  } stat_t;

  function automatic ctrl_t es_ucode(step_t step);
    ctrl_t w;
    w = '{in_rdy: 1'b0, rd_sel: RD_A, set_b: 1'b0, ld_acc: 1'b0, cmp: 1'b0,
          emit: 1'b0, cond: C_ALWAYS, tgt: STEP_LOAD, alt: STEP_LOAD};
    case (step)
      STEP_LOAD: begin
        w.in_rdy = 1'b1;
        w.cond   = C_IN_LAST;
        w.tgt    = STEP_RDA;
        w.alt    = STEP_LOAD;
      end
      STEP_RDA: begin
        w.rd_sel = RD_A;
        w.set_b  = 1'b1;
        w.cond   = C_ALWAYS;
        w.tgt    = STEP_LDA;
        w.alt    = STEP_LDA;
      end
      STEP_LDA: begin
        w.rd_sel = RD_B;
        w.ld_acc = 1'b1;
        w.cond   = C_B_END;
        w.tgt    = STEP_EMIT;
        w.alt    = STEP_CMP;
      end
      STEP_CMP: begin
        w.rd_sel = RD_BNEXT;
        w.cmp    = 1'b1;
        w.cond   = C_BNEXT_END;
        w.tgt    = STEP_EMIT;
        w.alt    = STEP_CMP;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_A_LAST;
        w.tgt  = STEP_LOAD;
        w.alt  = STEP_RDA;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = STEP_LOAD;
        w.alt  = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/es_if.sv =====
// Input and output stream interfaces of the exchange sorter.
// Depends on es_pkg.

interface es_in_if import es_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             last;

  modport source(output valid, value, last, input ready);
  modport sink(input valid, value, last, output ready);
endinterface

interface es_out_if import es_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value_res;
  logic             last_res;
  logic             overflow;

  modport source(output valid, value_res, last_res, overflow, input ready);
  modport sink(input valid, value_res, last_res, overflow, output ready);
endinterface

// ===== rtl/core/es_seq.sv =====
// Microprogram sequencer: step counter, control word lookup and conditional jumps.
// Depends on es_pkg.

module es_seq import es_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t step_q, step_d;
  ctrl_t word;
  logic  cond_hit;

  assign word   = es_ucode(step_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_IN_LAST:   cond_hit = stat_i.in_last_acc;
      C_B_END:     cond_hit = stat_i.b_end;
      C_BNEXT_END: cond_hit = stat_i.bnext_end;
      C_A_LAST:    cond_hit = stat_i.a_last;
      default:     cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    if (word.emit && !stat_i.out_free) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = word.tgt;
    end else begin
      step_d = word.alt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/core/es_dp.sv =====
// Datapath: element memory, count and index registers, compare-swap unit, output register.
// Depends on es_pkg; driven by the control word from es_seq.

module es_dp import es_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  logic             in_valid_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] out_value_o,
  output logic             out_last_o,
  output logic             out_ovf_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rd_q;
  logic [VAL_W-1:0] acc_q;
  logic [CW-1:0]    cnt_q, a_q, b_q;
  logic [CW-1:0]    a_inc, b_inc;
  logic             ovf_q;
  logic             out_valid_q, out_last_q, out_ovf_q;
  logic [VAL_W-1:0] out_value_q;
  logic             acc_in, has_room, swap, out_free, fire, a_last;
  logic [AW-1:0]    raddr;

  assign in_ready_o = ctrl_i.in_rdy;
  assign acc_in     = in_valid_i && ctrl_i.in_rdy;
  assign has_room   = cnt_q < CW'(DEPTH);
  assign a_inc      = a_q + 1'b1;
  assign b_inc      = b_q + 1'b1;
  assign swap       = $signed(acc_q) > $signed(rd_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = ctrl_i.emit && out_free;
  assign a_last     = a_inc == cnt_q;

  assign stat_o = '{in_last_acc: acc_in && in_last_i,
                    b_end:       b_q == cnt_q,
                    bnext_end:   b_inc == cnt_q,
                    a_last:      a_last,
                    out_free:    out_free};

  always_comb begin
    case (ctrl_i.rd_sel)
      RD_A:     raddr = a_q[AW-1:0];
      RD_B:     raddr = b_q[AW-1:0];
      RD_BNEXT: raddr = b_inc[AW-1:0];
      default:  raddr = a_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && has_room) begin
      mem_q[cnt_q[AW-1:0]] <= in_value_i;
    end else if (ctrl_i.cmp && swap) begin
      mem_q[b_q[AW-1:0]] <= acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    if (ctrl_i.ld_acc || (ctrl_i.cmp && swap)) begin
      acc_q <= rd_q;
    end
    if (fire) begin
      out_value_q <= acc_q;
      out_last_q  <= a_last;
      out_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_in) begin
        if (has_room) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (ctrl_i.in_rdy) begin
        a_q <= '0;
      end
      if (ctrl_i.set_b) begin
        b_q <= a_inc;
      end else if (ctrl_i.cmp) begin
        b_q <= b_inc;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        if (a_last) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          a_q   <= '0;
        end else begin
          a_q <= a_inc;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

// ===== rtl/core/exchange_sorter.sv =====
// Exchange sorter: collects a list of signed 32-bit values (the final transaction marked
// last), keeps up to DEPTH of them and emits them in ascending order. One input transaction
// is taken per cycle while loading. After the last one, the stored values are sorted and
// emitted: each position loads its value, then one compare-swap per later position
// through the element memory's single read port, then an emit step (held while the output
// is stalled). Values beyond DEPTH are dropped and every result of that list carries
// overflow. The next list may load while the final result still waits. No clearing pass
// after reset.
// Depends on es_pkg, es_if, es_seq and es_dp.

module exchange_sorter import es_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  es_in_if.sink          in_i,
  es_out_if.source       out_o
);

  ctrl_t ctrl;
  stat_t stat;

  es_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  es_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_i.valid),
    .in_value_i  (in_i.value),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.value_res),
    .out_last_o  (out_o.last_res),
    .out_ovf_o   (out_o.overflow)
  );

endmodule

// ===== rtl/core/es_chk.sv =====
// Port-level checker for the exchange sorter, bound to the top level.
// Depends on es_pkg and the exchange_sorter ports.

module es_chk import es_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_value,
  input logic             out_last,
  input logic             out_ovf
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction withdrawn");

  a_last_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken after last");

  a_load_only_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready && out_valid |-> out_last)
    else $error("loading while list output unfinished");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=>
      !out_valid || ($signed(out_value) >= $signed($past(out_value))))
    else $error("output not ascending");

  a_ovf_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> !out_valid || (out_ovf == $past(out_ovf)))
    else $error("overflow changed within a list");

endmodule

bind exchange_sorter es_chk u_es_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_last   (in_i.last),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_value (out_o.value_res),
  .out_last  (out_o.last_res),
  .out_ovf   (out_o.overflow)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for exchange_sorter: random and directed lists go in
// through a queued driver, and each sorted result is checked against an in-bench predictor.
// Depends on es_pkg, es_if and the exchange_sorter RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import es_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int ITEM_GOAL  = 430;
  localparam int LONG_HOLD  = 400;
  localparam int QUIET_MAX  = 4000;
  localparam int CALM_TAIL  = 60;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } list_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             ovf;
  } sorted_elem_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             drv_valid = 1'b0;
  logic [VAL_W-1:0] drv_value = '0;
  logic             drv_last  = 1'b0;
  logic             mon_ready = 1'b0;

  list_item_t   pending_items[$];
  sorted_elem_t sorted_expect_q[$];

  logic signed [VAL_W-1:0] held_vals[DEPTH];
  int held_count = 0;
  bit held_ovf   = 1'b0;

  int n_items     = 0;
  int in_accepted = 0;
  int send_gap    = 0;
  int recv_stall  = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  int quiet       = 0;
  int mismatches  = 0;

  es_in_if  in_if ();
  es_out_if out_if ();

  assign in_if.valid  = drv_valid;
  assign in_if.value  = drv_value;
  assign in_if.last   = drv_last;
  assign out_if.ready = mon_ready;

  exchange_sorter #(.DEPTH(DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit idling_on(int done);
    return (done + CALM_TAIL < n_items) && (((done / 48) % 4) != 3);
  endfunction

  task automatic push_item(input logic [VAL_W-1:0] v, input logic lst);
    list_item_t it;
    it.value = v;
    it.last  = lst;
    pending_items.push_back(it);
  endtask

  // Store or drop one element; on the last one sort what is held and queue the results.
  task automatic absorb_element(input logic [VAL_W-1:0] v, input logic lst);
    logic signed [VAL_W-1:0] t;
    sorted_elem_t e;
    if (held_count < DEPTH) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (lst) begin
      for (int a = 0; a + 1 < held_count; a++) begin
        for (int b = a + 1; b < held_count; b++) begin
          if (held_vals[a] > held_vals[b]) begin
            t            = held_vals[a];
            held_vals[a] = held_vals[b];
            held_vals[b] = t;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        e.value = held_vals[k];
        e.last  = (k == held_count - 1);
        e.ovf   = held_ovf;
        sorted_expect_q.push_back(e);
      end
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_item_t nxt;
    if (!rst_ni) begin
      drv_valid   <= 1'b0;
      drv_value   <= '0;
      drv_last    <= 1'b0;
      send_gap    <= 0;
      in_accepted <= 0;
    end else begin
      if (drv_valid && in_if.ready) begin
        absorb_element(drv_value, drv_last);
        in_accepted <= in_accepted + 1;
      end
      if (drv_valid && !in_if.ready) begin
        // hold the offered transaction
      end else if (send_gap != 0) begin
        drv_valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_items.size() != 0 && idling_on(in_accepted) &&
                   $urandom_range(0, 5) == 0) begin
        drv_valid <= 1'b0;
        send_gap  <= $urandom_range(0, 15);
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        drv_valid <= 1'b1;
        drv_value <= nxt.value;
        drv_last  <= nxt.last;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_elem_t want;
    if (!rst_ni) begin
      mon_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_if.valid && mon_ready) begin
        if (sorted_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value %0d last %0b overflow %0b",
                     $signed(out_if.value_res), out_if.last_res, out_if.overflow);
          mismatches++;
        end else begin
          want = sorted_expect_q.pop_front();
          if (out_if.value_res !== want.value || out_if.last_res !== want.last ||
              out_if.overflow !== want.ovf) begin
            if (mismatches < 10)
              $display("mismatch: value %0d/%0d last %0b/%0b overflow %0b/%0b (exp/act)",
                       $signed(want.value), $signed(out_if.value_res), want.last,
                       out_if.last_res, want.ovf, out_if.overflow);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        mon_ready  <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (idling_on(in_accepted) && $urandom_range(0, 7) == 0) begin
        mon_ready  <= 1'b0;
        recv_stall <= $urandom_range(0, 15);
      end else begin
        mon_ready <= (hold_left == 0);
      end
    end
  end

  // Hold off the receiver for a long stretch so the sorter backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && in_accepted >= 60) ||
                 (holds_done == 1 && in_accepted >= 250)) begin
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && in_if.ready) || (out_if.valid && mon_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet == QUIET_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int li;
    int pick;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] prev;

    push_item(VAL_MAX, 1'b1);
    push_item(VAL_MIN, 1'b1);
    push_item(VAL_MAX, 1'b0);
    push_item(VAL_MIN, 1'b0);
    push_item('1, 1'b0);
    push_item('0, 1'b0);
    push_item(1, 1'b1);
    push_item(7, 1'b0);
    push_item(7, 1'b0);
    push_item(-3, 1'b0);
    push_item(7, 1'b1);
    for (int k = 5; k >= 1; k--)
      push_item(k, k == 1);
    push_item(1, 1'b0);
    push_item('1, 1'b1);

    li   = 0;
    prev = '0;
    while (pending_items.size() < ITEM_GOAL) begin
      if (li == 0) begin
        len = DEPTH + $urandom_range(1, 4);
      end else if (li == 1) begin
        len = DEPTH;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick <= 5)      len = $urandom_range(1, 8);
        else if (pick <= 7) len = $urandom_range(9, DEPTH - 1);
        else if (pick == 8) len = DEPTH;
        else                len = DEPTH + $urandom_range(1, 8);
      end
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 7);
        case (pick)
          4, 5:    v = $urandom_range(0, 15) - 8;
          6: begin
            case ($urandom_range(0, 4))
              0:       v = VAL_MAX;
              1:       v = VAL_MIN;
              2:       v = '1;
              3:       v = '0;
              default: v = 1;
            endcase
          end
          7:       v = prev;
          default: v = $urandom;
        endcase
        prev = v;
        push_item(v, k == len - 1);
      end
      li++;
    end
    n_items = pending_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (in_accepted != n_items || sorted_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (mismatches == 0 && sorted_expect_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
